// ===== design/scp_pkg.sv =====
// ---------------------------------------------------------------------------
// scp_pkg: shared types and constants for the sine / cosine polynomial unit
// Fixed-point formats, reduction constants, Horner coefficients and the
// sideband struct that travels down the pipeline with each beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

  // Input angle and result formats
  localparam int ANGLE_W         = 32;
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int OUT_W           = 32;
  localparam int OUT_FRAC_BITS   = 30;

  // Internal polynomial format (Q.30)
  localparam int QW     = 30;
  localparam int ACC_W  = 34;               // signed Horner accumulator
  localparam int MAG_W  = ACC_W - 1;        // accumulator magnitude
  localparam int MULB_W = 32;               // unsigned multiplier operand
  localparam int PROD_W = MAG_W + MULB_W;   // full product

  // Reduction widths
  localparam int AMAG_W = ANGLE_W;          // |angle|, up to 2^31
  localparam int T_W    = 62;               // |angle| * 1/(2*pi)
  localparam int Q_W    = 31 - ANGLE_FRAC_BITS;
  localparam int Y_W    = 65 - ANGLE_FRAC_BITS;
  localparam int YM_W   = 31;               // folded magnitude, Q.30
  localparam int Y2_W   = 32;               // squared magnitude, Q.30

  // Reduction constants, Q.32
  localparam logic [63:0] INV_TWO_PI = 64'd683565276;
  localparam logic [63:0] TWO_PI     = 64'd26986075409;
  localparam logic [63:0] PI         = 64'd13493037705;
  localparam logic [63:0] HALF_PI    = 64'd6746518852;
  localparam logic [63:0] Q_RND      = 64'd1 << (ANGLE_FRAC_BITS + 31);

  // Horner coefficients, Q.30, highest order first; last entry is the 1.0 term
  localparam int N_COEF = 6;
  localparam logic signed [ACC_W-1:0] SIN_K [N_COEF] = '{
    -34'sd26, 34'sd2956, -34'sd213040, 34'sd8947846, -34'sd178956974, 34'sd1073741824
  };
  localparam logic signed [ACC_W-1:0] COS_K [N_COEF] = '{
    -34'sd280, 34'sd26586, -34'sd1491253, 34'sd44739212, -34'sd536870912, 34'sd1073741824
  };

  // Function select codes
  localparam logic FUNC_SIN = 1'b0;
  localparam logic FUNC_COS = 1'b1;

  // Per-beat sideband carried alongside the arithmetic
  typedef struct packed {
    logic             func;
    logic             cos_neg;
    logic             sin_neg;
    logic [YM_W-1:0]  ym;
    logic [Y2_W-1:0]  y2;
  } side_t;

endpackage

`default_nettype wire

// ===== design/scp_reduce.sv =====
// ---------------------------------------------------------------------------
// scp_reduce: range reduction front end
// Registers the command, reduces the angle modulo 2*pi with a rounded
// quotient, folds it into [-pi/2, pi/2] and forms the Q.30 magnitude.
// Six register stages, one beat per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scp_reduce
  import scp_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic                       func_i,
  input  wire logic signed [ANGLE_W-1:0]  angle_i,
  output logic                            valid_o,
  output side_t                           side_o
);

  // Stage valid bits
  logic [5:0] vld_q;

  // Stage 0: captured command
  logic               func0_q;
  logic [ANGLE_W-1:0] raw0_q;

  // Stage 1: magnitude and product with 1/(2*pi)
  logic              a_neg1_q, func1_q;
  logic [AMAG_W-1:0] amag1_d, amag1_q;
  logic [T_W-1:0]    t1_d, t1_q;

  // Stage 2: rounded quotient
  logic              a_neg2_q, func2_q;
  logic [AMAG_W-1:0] amag2_q;
  logic [T_W:0]      tsum;
  logic [Q_W-1:0]    q2_d, q2_q;

  // Stage 3: remainder
  logic                  a_neg3_q, func3_q;
  logic [Y_W-1:0]        a32, qtp;
  logic signed [Y_W-1:0] y3_d, y3_q;

  // Stage 4: folded remainder
  logic                  a_neg4_q, func4_q, cneg4_d, cneg4_q;
  logic signed [Y_W-1:0] y4_d, y4_q;

  // Stage 5: Q.30 magnitude
  logic [Y_W-1:0] ymag;
  side_t          side5_d, side5_q;

  // Advance valid bits every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // Magnitude of the angle; the most negative code maps to 2^31
  always_comb begin
    amag1_d = raw0_q[ANGLE_W-1] ? (~raw0_q + AMAG_W'(1)) : raw0_q;
    t1_d    = T_W'(amag1_d) * T_W'(INV_TWO_PI);
  end

  // Round the quotient half away from zero on the magnitude
  always_comb begin
    tsum = (T_W+1)'(t1_q) + (T_W+1)'(Q_RND);
    q2_d = tsum[T_W -: Q_W];
  end

  // Subtract q * 2*pi from the Q.32 angle
  always_comb begin
    a32  = Y_W'(amag2_q) << (32 - ANGLE_FRAC_BITS);
    qtp  = Y_W'(q2_q) * Y_W'(TWO_PI);
    y3_d = $signed(a32 - qtp);
  end

  // Fold into [-pi/2, pi/2]; exactly pi/2 stays as is
  always_comb begin
    y4_d    = y3_q;
    cneg4_d = 1'b0;
    if (y3_q > $signed(Y_W'(HALF_PI))) begin
      y4_d    = $signed(Y_W'(PI)) - y3_q;
      cneg4_d = 1'b1;
    end else if (y3_q < -$signed(Y_W'(HALF_PI))) begin
      y4_d    = -$signed(Y_W'(PI)) - y3_q;
      cneg4_d = 1'b1;
    end
  end

  // Round the magnitude into Q.30 and set the sine sign
  always_comb begin
    ymag            = y4_q[Y_W-1] ? Y_W'(-y4_q) : Y_W'(y4_q);
    side5_d.func    = func4_q;
    side5_d.cos_neg = cneg4_q;
    side5_d.sin_neg = y4_q[Y_W-1] ^ a_neg4_q;
    side5_d.ym      = YM_W'((ymag + Y_W'(2)) >> 2);
    side5_d.y2      = '0;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func0_q  <= func_i;
    raw0_q   <= angle_i;
    a_neg1_q <= raw0_q[ANGLE_W-1];
    func1_q  <= func0_q;
    amag1_q  <= amag1_d;
    t1_q     <= t1_d;
    a_neg2_q <= a_neg1_q;
    func2_q  <= func1_q;
    amag2_q  <= amag1_q;
    q2_q     <= q2_d;
    a_neg3_q <= a_neg2_q;
    func3_q  <= func2_q;
    y3_q     <= y3_d;
    a_neg4_q <= a_neg3_q;
    func4_q  <= func3_q;
    cneg4_q  <= cneg4_d;
    y4_q     <= y4_d;
    side5_q  <= side5_d;
  end

  assign valid_o = vld_q[5];
  assign side_o  = side5_q;

endmodule

`default_nettype wire

// ===== design/scp_mac.sv =====
// ---------------------------------------------------------------------------
// scp_mac: one Horner step
// Multiplies a signed Q.30 accumulator by an unsigned Q.30 operand, rounds
// the magnitude to nearest with ties away from zero, restores the sign and
// adds a coefficient. Two register stages: product, then round and add.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scp_mac
  import scp_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic signed [ACC_W-1:0]  a_i,
  input  wire logic [MULB_W-1:0]        b_i,
  input  wire logic signed [ACC_W-1:0]  k_i,
  input  wire logic                     bypass_i,
  input  wire side_t                    side_i,
  output logic                          valid_o,
  output logic signed [ACC_W-1:0]       res_o,
  output side_t                         side_o
);

  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (QW - 1);

  logic [1:0] vld_q;

  // Product stage
  logic [MAG_W-1:0]        amag;
  logic [PROD_W-1:0]       prod_d, prod_q;
  logic                    neg_q, byp_q;
  logic signed [ACC_W-1:0] a_q, k_q;
  side_t                   side1_q;

  // Round and add stage
  logic [PROD_W-1:0]       rnd_sum;
  logic [ACC_W-1:0]        rmag;
  logic signed [ACC_W-1:0] res_d, res_q;
  side_t                   side2_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  // Multiply magnitudes
  always_comb begin
    amag   = a_i[ACC_W-1] ? MAG_W'(-a_i) : MAG_W'(a_i);
    prod_d = PROD_W'(amag) * PROD_W'(b_i);
  end

  // Round, restore sign, add coefficient; bypass hands the operand through
  always_comb begin
    rnd_sum = prod_q + RND;
    rmag    = ACC_W'(rnd_sum >> QW);
    if (byp_q) begin
      res_d = a_q;
    end else if (neg_q) begin
      res_d = $signed(-rmag) + k_q;
    end else begin
      res_d = $signed(rmag) + k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    neg_q   <= a_i[ACC_W-1];
    byp_q   <= bypass_i;
    a_q     <= a_i;
    k_q     <= k_i;
    side1_q <= side_i;
    res_q   <= res_d;
    side2_q <= side1_q;
  end

  assign valid_o = vld_q[1];
  assign res_o   = res_q;
  assign side_o  = side2_q;

endmodule

`default_nettype wire

// ===== design/sine_cosine_polynomial.sv =====
// ---------------------------------------------------------------------------
// sine_cosine_polynomial: fixed-point sine / cosine by minimax polynomials
// Takes a Q7.24 angle in radians and returns sine or cosine in Q2.30,
// saturated to plus or minus one.
// ---------------------------------------------------------------------------
// Usage: the unit takes one command per clock cycle; busy_o stays low, so a
// beat is taken whenever start_i is high. Each result appears on
// trig_value_o for a single cycle with valid_o high, in command order; it
// must be taken then because the output cannot be held off. The pipeline
// is made up of the six range reduction stages, seven multiply-round-add
// steps (the squaring, five Horner steps and the final multiply by the
// angle) and one output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sine_cosine_polynomial
  import scp_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic                      func_i,
  input  wire logic signed [ANGLE_W-1:0] angle_i,
  output logic                           valid_o,
  output logic signed [OUT_W-1:0]        trig_value_o
);

  localparam int N_MAC    = 7;
  localparam int PIPE_LAT = 6 + 2 * N_MAC + 1;
  localparam int OUT_SH   = QW - OUT_FRAC_BITS;
  localparam logic [ACC_W-1:0] ONE_Q   = ACC_W'(1) << QW;
  localparam logic [ACC_W-1:0] OUT_RND = ACC_W'((2 ** OUT_SH) / 2);
  localparam logic [ACC_W-1:0] OUT_MAX = ACC_W'(1) << OUT_FRAC_BITS;

  logic accept;
  logic red_valid;
  side_t red_side;

  // Multiply chain wiring
  logic                    mac_vin  [N_MAC];
  logic signed [ACC_W-1:0] mac_a    [N_MAC];
  logic [MULB_W-1:0]       mac_b    [N_MAC];
  logic signed [ACC_W-1:0] mac_k    [N_MAC];
  logic                    mac_byp  [N_MAC];
  side_t                   mac_sin  [N_MAC];
  logic                    mac_vout [N_MAC];
  logic signed [ACC_W-1:0] mac_res  [N_MAC];
  side_t                   mac_sout [N_MAC];
  side_t                   sq_side;

  // Output stage
  logic                    fin_neg;
  logic [ACC_W-1:0]        fin_mag, fin_sat, fin_rnd, fin_lim;
  logic                    valid_q;
  logic signed [OUT_W-1:0] trig_d, trig_q;

  // No back-pressure: a beat is taken whenever start_i is high
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  scp_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .func_i  (func_i),
    .angle_i (angle_i),
    .valid_o (red_valid),
    .side_o  (red_side)
  );

  // Square the folded magnitude
  assign mac_vin[0] = red_valid;
  assign mac_a[0]   = $signed(ACC_W'(red_side.ym));
  assign mac_b[0]   = MULB_W'(red_side.ym);
  assign mac_k[0]   = '0;
  assign mac_byp[0] = 1'b0;
  assign mac_sin[0] = red_side;

  // Capture the square into the sideband
  always_comb begin
    sq_side    = mac_sout[0];
    sq_side.y2 = Y2_W'(mac_res[0]);
  end

  // Horner steps on the square
  for (genvar i = 1; i < N_COEF; i++) begin : g_horner
    assign mac_vin[i] = mac_vout[i-1];
    assign mac_b[i]   = (i == 1) ? sq_side.y2 : mac_sout[i-1].y2;
    assign mac_k[i]   = (mac_sin[i].func == FUNC_COS) ? COS_K[i] : SIN_K[i];
    assign mac_byp[i] = 1'b0;
    assign mac_sin[i] = (i == 1) ? sq_side : mac_sout[i-1];
    if (i == 1) begin : g_first
      assign mac_a[i] = (sq_side.func == FUNC_COS) ? COS_K[0] : SIN_K[0];
    end else begin : g_rest
      assign mac_a[i] = mac_res[i-1];
    end
  end

  // Final multiply by the angle for sine; cosine passes through
  assign mac_vin[N_MAC-1] = mac_vout[N_MAC-2];
  assign mac_a[N_MAC-1]   = mac_res[N_MAC-2];
  assign mac_b[N_MAC-1]   = MULB_W'(mac_sout[N_MAC-2].ym);
  assign mac_k[N_MAC-1]   = '0;
  assign mac_byp[N_MAC-1] = (mac_sout[N_MAC-2].func == FUNC_COS);
  assign mac_sin[N_MAC-1] = mac_sout[N_MAC-2];

  for (genvar j = 0; j < N_MAC; j++) begin : g_mac
    scp_mac u_mac (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (mac_vin[j]),
      .a_i      (mac_a[j]),
      .b_i      (mac_b[j]),
      .k_i      (mac_k[j]),
      .bypass_i (mac_byp[j]),
      .side_i   (mac_sin[j]),
      .valid_o  (mac_vout[j]),
      .res_o    (mac_res[j]),
      .side_o   (mac_sout[j])
    );
  end

  // Apply sign, saturate, round to the output format
  always_comb begin
    fin_neg = (mac_sout[N_MAC-1].func == FUNC_COS) ? mac_sout[N_MAC-1].cos_neg
                                                    : mac_sout[N_MAC-1].sin_neg;
    if (mac_res[N_MAC-1][ACC_W-1]) begin
      fin_mag = ACC_W'(-mac_res[N_MAC-1]);
      fin_neg = !fin_neg;
    end else begin
      fin_mag = ACC_W'(mac_res[N_MAC-1]);
    end
    fin_sat = (fin_mag > ONE_Q) ? ONE_Q : fin_mag;
    fin_rnd = (fin_sat + OUT_RND) >> OUT_SH;
    fin_lim = (fin_rnd > OUT_MAX) ? OUT_MAX : fin_rnd;
    trig_d  = fin_neg ? $signed(-OUT_W'(fin_lim)) : $signed(OUT_W'(fin_lim));
  end

  // Hold the result strobe for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= mac_vout[N_MAC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
  end

  assign valid_o      = valid_q;
  assign trig_value_o = trig_q;

  // Every accepted beat yields a result on valid_o
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_LAT valid_o)
    else $error("accepted beat produced no result");

  // No result without a matching accepted beat
  a_lat_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, PIPE_LAT))
    else $error("result without accepted beat");

  // Result stays within plus or minus one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (trig_value_o <= $signed(OUT_W'(OUT_MAX)))
             && (trig_value_o >= -$signed(OUT_W'(OUT_MAX))))
    else $error("result out of range");

endmodule

`default_nettype wire
